[hdl/dmcl_pkg.sv]
// Shared types and constants for the direct-mapped cache lookup core.
// Depends on nothing; every other file refers to it by scoped names.
package dmcl_pkg;

    localparam int NUM_LINES   = 128;
    localparam int BLOCK_BYTES = 32;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int LINE_W   = $clog2(NUM_LINES);
    localparam int TAG_W    = 20;
    localparam int CNT_W    = 32;

    // Fixed widths of the result fields
    localparam int OUT_OFFSET_W = 5;
    localparam int OUT_BLOCK_W  = 27;
    localparam int OUT_LINE_W   = 7;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Request from the control FSM to the lookup unit
    typedef struct packed {
        logic              commit;
        logic [LINE_W-1:0] index;
        logic [TAG_W-1:0]  tag;
        logic [TAG_W-1:0]  stored_tag;
    } t_lookup_req;

    // Outcome of the lookup, valid while a request sits in the lookup stage
    typedef struct packed {
        logic             miss;
        logic             replacement;
        logic [TAG_W-1:0] evicted_tag;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
    } t_lookup_rsp;

endpackage

[hdl/direct_mapped_cache_lookup_core.sv]
// Top level of the direct-mapped cache tag lookup core.
// Depends on dmcl_pkg, dmcl_tag_ram and dmcl_lookup.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: a 32-bit
//   byte address. Output channel (o_out_valid / i_out_ready) carries one
//   result per request: the address split into byte offset, block number,
//   line index and tag, the hit/miss flag, whether a valid line holding
//   another tag was replaced together with its old tag (zero otherwise),
//   and the running hit and miss counts including this request.
//   Order: an accepted request is held in the lookup stage, and its result is
//   registered into the output register when the lookup commits.
//   Flow: the tag RAM has a registered read; the lookup reads the line in
//   the accept cycle and, on a miss, writes the new tag back when it
//   commits, and the next request is taken only after that commit, so two
//   requests never touch the RAM at the same time.
//   Reset: synchronous, active low. All line valid bits, both counters and
//   the channel state clear; the tag RAM is not cleared, an
//   invalid line never has its tag observed.
//   Stall: a held result sits in the output register; one more request may
//   be accepted and waits in the lookup stage until the output register
//   frees up, while the input stays not ready.
module direct_mapped_cache_lookup_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dmcl_pkg::ADDR_W-1:0]       i_address,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dmcl_pkg::OUT_OFFSET_W-1:0] o_byte_offset,
    output logic [dmcl_pkg::OUT_BLOCK_W-1:0]  o_block_number,
    output logic [dmcl_pkg::OUT_LINE_W-1:0]   o_line_index,
    output logic [dmcl_pkg::TAG_W-1:0]        o_tag_value,
    output logic                              o_miss,
    output logic                              o_replacement,
    output logic [dmcl_pkg::TAG_W-1:0]        o_evicted_tag,
    output logic [dmcl_pkg::CNT_W-1:0]        o_hit_count,
    output logic [dmcl_pkg::CNT_W-1:0]        o_miss_count
);

    // Control
    dmcl_pkg::t_state r_state;
    dmcl_pkg::t_state n_state;
    logic             w_accept;
    logic             w_commit;
    logic             w_out_free;

    // Request held in the lookup stage
    logic [dmcl_pkg::ADDR_W-1:0] r_addr;

    // Address split, for the incoming address (RAM read) and the held one
    logic [dmcl_pkg::ADDR_W-1:0] w_in_block;
    logic [dmcl_pkg::ADDR_W-1:0] w_in_line;
    logic [dmcl_pkg::ADDR_W-1:0] w_offset;
    logic [dmcl_pkg::ADDR_W-1:0] w_block;
    logic [dmcl_pkg::ADDR_W-1:0] w_line;
    logic [dmcl_pkg::ADDR_W-1:0] w_tag;

    logic [dmcl_pkg::TAG_W-1:0] w_stored_tag;
    dmcl_pkg::t_lookup_req      w_req;
    dmcl_pkg::t_lookup_rsp      w_rsp;

    // Output register
    logic                              r_out_valid;
    logic [dmcl_pkg::OUT_OFFSET_W-1:0] r_byte_offset;
    logic [dmcl_pkg::OUT_BLOCK_W-1:0]  r_block_number;
    logic [dmcl_pkg::OUT_LINE_W-1:0]   r_line_index;
    logic [dmcl_pkg::TAG_W-1:0]        r_tag_value;
    logic                              r_miss;
    logic                              r_replacement;
    logic [dmcl_pkg::TAG_W-1:0]        r_evicted_tag;
    logic [dmcl_pkg::CNT_W-1:0]        r_hit_count;
    logic [dmcl_pkg::CNT_W-1:0]        r_miss_count;

    // Split addresses: block sizes and line counts are powers of two,
    // so divide and modulo reduce to shifts and masks.
    assign w_in_block = i_address / dmcl_pkg::BLOCK_BYTES;
    assign w_in_line  = w_in_block % dmcl_pkg::NUM_LINES;

    assign w_offset = r_addr % dmcl_pkg::BLOCK_BYTES;
    assign w_block  = r_addr / dmcl_pkg::BLOCK_BYTES;
    assign w_line   = w_block % dmcl_pkg::NUM_LINES;
    assign w_tag    = w_block / dmcl_pkg::NUM_LINES;

    // Output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and handshake: take a request in idle, then commit the
    // lookup once the RAM data is back and the output register can take it.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            dmcl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = dmcl_pkg::ST_LOOKUP;
                end
            end
            dmcl_pkg::ST_LOOKUP: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = dmcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dmcl_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmcl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request address for the lookup stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= i_address;
        end
    end

    // Tag RAM: read on accept, write back the new tag on a committed miss
    dmcl_tag_ram u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_line[dmcl_pkg::LINE_W-1:0]),
        .o_rd_data (w_stored_tag),
        .i_wr_en   (w_commit && w_rsp.miss),
        .i_wr_addr (w_line[dmcl_pkg::LINE_W-1:0]),
        .i_wr_data (w_tag[dmcl_pkg::TAG_W-1:0])
    );

    always_comb begin
        w_req.commit     = w_commit;
        w_req.index      = w_line[dmcl_pkg::LINE_W-1:0];
        w_req.tag        = w_tag[dmcl_pkg::TAG_W-1:0];
        w_req.stored_tag = w_stored_tag;
    end

    dmcl_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Output valid: set on commit, drop when the receiver takes the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load on commit, otherwise hold
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_byte_offset  <= w_offset[dmcl_pkg::OUT_OFFSET_W-1:0];
            r_block_number <= w_block[dmcl_pkg::OUT_BLOCK_W-1:0];
            r_line_index   <= w_line[dmcl_pkg::OUT_LINE_W-1:0];
            r_tag_value    <= w_tag[dmcl_pkg::TAG_W-1:0];
            r_miss         <= w_rsp.miss;
            r_replacement  <= w_rsp.replacement;
            r_evicted_tag  <= w_rsp.evicted_tag;
            r_hit_count    <= w_rsp.hit_count;
            r_miss_count   <= w_rsp.miss_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_offset  = r_byte_offset;
    assign o_block_number = r_block_number;
    assign o_line_index   = r_line_index;
    assign o_tag_value    = r_tag_value;
    assign o_miss         = r_miss;
    assign o_replacement  = r_replacement;
    assign o_evicted_tag  = r_evicted_tag;
    assign o_hit_count    = r_hit_count;
    assign o_miss_count   = r_miss_count;

    // A commit always leaves a result in the output register
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("committed lookup produced no result");

    // An accepted request is committed only in the following cycle or later
    a_no_accept_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_commit)
        else $error("accept and commit in the same cycle");

    // No eviction reports a zero evicted tag
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_replacement |-> o_evicted_tag == '0)
        else $error("evicted tag nonzero without replacement");

    // A request in the lookup stage keeps the input channel closed
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmcl_pkg::ST_LOOKUP) |-> !o_in_ready)
        else $error("input ready while a lookup is in flight");

endmodule

[hdl/dmcl_tag_ram.sv]
// Tag store of the cache: one write port, one read port with registered data.
// Depends on dmcl_pkg for the depth and tag width.
module dmcl_tag_ram (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [dmcl_pkg::LINE_W-1:0]  i_rd_addr,
    output logic [dmcl_pkg::TAG_W-1:0]   o_rd_data,
    input  logic                         i_wr_en,
    input  logic [dmcl_pkg::LINE_W-1:0]  i_wr_addr,
    input  logic [dmcl_pkg::TAG_W-1:0]   i_wr_data
);

    logic [dmcl_pkg::TAG_W-1:0] r_mem [dmcl_pkg::NUM_LINES];
    logic [dmcl_pkg::TAG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/dmcl_lookup.sv]
// Hit/miss decision: line valid bits, tag compare and the running counters.
// Depends on dmcl_pkg for the request and response structs.
module dmcl_lookup (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmcl_pkg::t_lookup_req i_req,
    output dmcl_pkg::t_lookup_rsp o_rsp
);

    logic [dmcl_pkg::NUM_LINES-1:0] r_valid;
    logic [dmcl_pkg::CNT_W-1:0]     r_hits;
    logic [dmcl_pkg::CNT_W-1:0]     r_misses;
    logic [dmcl_pkg::CNT_W-1:0]     n_hits;
    logic [dmcl_pkg::CNT_W-1:0]     n_misses;
    logic                           w_line_valid;
    logic                           w_tag_eq;

    assign w_line_valid = r_valid[i_req.index];
    assign w_tag_eq     = (i_req.stored_tag == i_req.tag);

    always_comb begin
        o_rsp.miss        = !(w_line_valid && w_tag_eq);
        o_rsp.replacement = w_line_valid && !w_tag_eq;
        o_rsp.evicted_tag = o_rsp.replacement ? i_req.stored_tag
                                              : '0;
        n_hits   = o_rsp.miss ? r_hits : r_hits + dmcl_pkg::CNT_W'(1);
        n_misses = o_rsp.miss ? r_misses + dmcl_pkg::CNT_W'(1) : r_misses;
        o_rsp.hit_count  = n_hits;
        o_rsp.miss_count = n_misses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_req.commit) begin
            r_valid[i_req.index] <= 1'b1;
            r_hits               <= n_hits;
            r_misses             <= n_misses;
        end
    end

    // Exactly one counter advances per committed lookup
    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.commit |=> (r_hits + r_misses) == $past(r_hits + r_misses) + 32'd1)
        else $error("counters did not advance by one");

    // A committed line is valid afterwards
    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.commit |=> r_valid[$past(i_req.index)])
        else $error("committed line not marked valid");

    // Replacement only with a valid line and a differing tag
    a_repl_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.replacement |-> o_rsp.miss && w_line_valid)
        else $error("replacement without a valid miss");

endmodule
